@@ rtl/core/spq_pkg.sv @@
// ---------------------------------------------------------------------------
// spq_pkg : shared types and codes for the stable priority queue
// Request and status codes, fixed field widths and the word types that
// travel along the cell chain.
// ---------------------------------------------------------------------------
package spq_pkg;

   // fixed field widths
   localparam int PRIO_W   = 8;
   localparam int RECORD_W = 16;
   localparam int AGE_W    = 8;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   // parameter defaults
   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_PRIO_BITS   = 8;

   // request codes
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // payload carried with each entry, apart from its key
   typedef struct packed {
      logic [RECORD_W-1:0] record;
      logic [AGE_W-1:0]    age;
   } spq_data_type;

   // operation broadcast to every cell
   typedef struct packed {
      logic ins;   // insert, queue not full
      logic rem;   // remove, queue not empty
   } spq_ctl_type;

endpackage

@@ rtl/core/stable_priority_queue.sv @@
// ---------------------------------------------------------------------------
// stable_priority_queue : bounded priority queue on a sorted cell chain
// Entries are kept highest priority first; equal priorities leave in
// arrival order. Insert into a full queue and remove from an empty one
// leave the contents alone and are flagged in the status.
// ---------------------------------------------------------------------------
//
//  channel   strobe / hold     ports
//  -------   --------------    -------------------------------------------
//  request   start, busy       req_type req_prio req_record_no req_patient_age
//  response  rsp_strobe        rsp_removed_* rsp_status rsp_occupancy
//
//  One word is taken every clock; its response shows in the next cycle for
//  exactly one cycle. This rests on the compare-and-shift that every
//  cell does against the broadcast key.
//  Reset clears the slot valid bits, the count and the response strobe;
//  slot contents are not cleared.
//  busy stays low; the receiver cannot stall, so nothing is held back.
//
module stable_priority_queue #(
   parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH,
   parameter int PRIO_BITS   = spq_pkg::DEF_PRIO_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_type,
   input  logic [spq_pkg::PRIO_W-1:0]       req_prio,
   input  logic [spq_pkg::RECORD_W-1:0]     req_record_no,
   input  logic [spq_pkg::AGE_W-1:0]        req_patient_age,
   output logic                             rsp_strobe,
   output logic                             rsp_removed_valid,
   output logic [spq_pkg::PRIO_W-1:0]       rsp_removed_prio,
   output logic [spq_pkg::RECORD_W-1:0]     rsp_removed_record,
   output logic [spq_pkg::AGE_W-1:0]        rsp_removed_age,
   output logic [spq_pkg::STATUS_W-1:0]     rsp_status,
   output logic [spq_pkg::OCC_W-1:0]        rsp_occupancy
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // chain taps, one per cell, each read at its own fixed place
   logic [QUEUE_DEPTH-1:0] cell_go;
   logic [QUEUE_DEPTH-1:0] cell_used;
   logic [PRIO_BITS-1:0]   cell_prio [QUEUE_DEPTH];
   spq_data_type           cell_data [QUEUE_DEPTH];

   logic                 accept;
   logic                 full;
   logic                 empty;
   logic [PRIO_BITS-1:0] key;
   spq_data_type         new_data;
   spq_ctl_type          ctl;

   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic                   strobe_ff;
   logic                   rvalid_ff, rvalid_in;
   logic [PRIO_W-1:0]      rprio_ff, rprio_in;
   logic [RECORD_W-1:0]    rrec_ff, rrec_in;
   logic [AGE_W-1:0]       rage_ff, rage_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [OCC_W-1:0]       occ_ff, occ_in;

   // never holds the requester off
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // valid bits form a prefix: last set means full, first clear means empty
   assign full  = cell_used[QUEUE_DEPTH-1];
   assign empty = !cell_used[0];

   // key: low PRIO_BITS of the request priority, zero-filled above 8 bits
   always_comb begin
      key = '0;
      for (int b = 0; b < PRIO_BITS; b++) begin
         if (b < PRIO_W) begin
            key[b] = req_prio[b];
         end
      end
   end

   assign new_data.record = req_record_no;
   assign new_data.age    = req_patient_age;

   assign ctl.ins = accept && (req_type == REQ_INSERT) && !full;
   assign ctl.rem = accept && (req_type == REQ_REMOVE) && !empty;

   // ---- the chain ----
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                 l_go, l_used, r_used;
      logic [PRIO_BITS-1:0] l_prio, r_prio;
      spq_data_type         l_data, r_data;

      if (i == 0) begin : g_head
         // head sees an always-staying, always-used left edge
         assign l_go   = 1'b1;
         assign l_used = 1'b1;
         assign l_prio = key;
         assign l_data = new_data;
      end else begin : g_mid
         assign l_go   = cell_go[i-1];
         assign l_used = cell_used[i-1];
         assign l_prio = cell_prio[i-1];
         assign l_data = cell_data[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign r_used = 1'b0;
         assign r_prio = '0;
         assign r_data = '0;
      end else begin : g_body
         assign r_used = cell_used[i+1];
         assign r_prio = cell_prio[i+1];
         assign r_data = cell_data[i+1];
      end

      spq_cell #(
         .PRIO_BITS (PRIO_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .new_prio   (key),
         .new_data   (new_data),
         .left_go    (l_go),
         .left_used  (l_used),
         .left_prio  (l_prio),
         .left_data  (l_data),
         .right_used (r_used),
         .right_prio (r_prio),
         .right_data (r_data),
         .go         (cell_go[i]),
         .used       (cell_used[i]),
         .prio       (cell_prio[i]),
         .data       (cell_data[i])
      );
   end

   // ---- count and response word ----
   always_comb begin
      cnt_in    = cnt_ff;
      rvalid_in = 1'b0;
      rprio_in  = '0;
      rrec_in   = '0;
      rage_in   = '0;
      status_in = STATUS_OK;
      if (ctl.ins) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (ctl.rem) begin
         cnt_in    = cnt_ff - CNT_W'(1);
         rvalid_in = 1'b1;
         rrec_in   = cell_data[0].record;
         rage_in   = cell_data[0].age;
         for (int b = 0; b < PRIO_W; b++) begin
            if (b < PRIO_BITS) begin
               rprio_in[b] = cell_prio[0][b];
            end
         end
      end else if (req_type == REQ_INSERT) begin
         status_in = STATUS_FULL;
      end else begin
         status_in = STATUS_EMPTY;
      end
   end

   // occupancy reported in its low OCC_W bits
   always_comb begin
      occ_in = '0;
      for (int b = 0; b < OCC_W; b++) begin
         if (b < CNT_W) begin
            occ_in[b] = cnt_in[b];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= accept;
         if (accept) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rvalid_ff <= rvalid_in;
         rprio_ff  <= rprio_in;
         rrec_ff   <= rrec_in;
         rage_ff   <= rage_in;
         status_ff <= status_in;
         occ_ff    <= occ_in;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_removed_valid  = rvalid_ff;
   assign rsp_removed_prio   = rprio_ff;
   assign rsp_removed_record = rrec_ff;
   assign rsp_removed_age    = rage_ff;
   assign rsp_status         = status_ff;
   assign rsp_occupancy      = occ_ff;

`ifndef SYNTHESIS
   // count agrees with the valid bits held in the chain
   a_cnt_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_used) == 32'(cnt_ff))
      else $error("entry count out of step with cell valid bits");

   // head never ranks below its successor
   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      cell_used[1] |-> (cell_prio[0] >= cell_prio[1]))
      else $error("head entry out of order");

   // every accepted word gets its response next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("response strobe missing");

   // a returned entry always comes with an ok status
   a_valid_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_removed_valid) |-> (rsp_status == STATUS_OK))
      else $error("removed entry with error status");
`endif

endmodule

@@ rtl/core/spq_cell.sv @@
// ---------------------------------------------------------------------------
// spq_cell : one slot of the sorted chain
// Holds one entry; on insert keeps, takes the new word or shifts from the
// left, on remove shifts from the right.
// ---------------------------------------------------------------------------
module spq_cell #(
   parameter int PRIO_BITS = spq_pkg::DEF_PRIO_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  spq_pkg::spq_ctl_type ctl,
   input  logic [PRIO_BITS-1:0] new_prio,
   input  spq_pkg::spq_data_type new_data,
   input  logic                 left_go,
   input  logic                 left_used,
   input  logic [PRIO_BITS-1:0] left_prio,
   input  spq_pkg::spq_data_type left_data,
   input  logic                 right_used,
   input  logic [PRIO_BITS-1:0] right_prio,
   input  spq_pkg::spq_data_type right_data,
   output logic                 go,
   output logic                 used,
   output logic [PRIO_BITS-1:0] prio,
   output spq_pkg::spq_data_type data
);
   import spq_pkg::*;

   logic                 used_ff, used_in;
   logic [PRIO_BITS-1:0] prio_ff, prio_in;
   spq_data_type         data_ff, data_in;

   // entry stays put when it ranks at or above the new key
   assign go = used_ff && (prio_ff >= new_prio);

   always_comb begin
      prio_in = prio_ff;
      data_in = data_ff;
      used_in = used_ff;
      if (ctl.ins) begin
         if (!go) begin
            if (left_go) begin
               prio_in = new_prio;
               data_in = new_data;
            end else begin
               prio_in = left_prio;
               data_in = left_data;
            end
         end
         used_in = used_ff | left_used;
      end else if (ctl.rem) begin
         prio_in = right_prio;
         data_in = right_data;
         used_in = right_used;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      data_ff <= data_in;
   end

   assign used = used_ff;
   assign prio = prio_ff;
   assign data = data_ff;

endmodule
